@@ hw/rtl/swmf_pkg.sv @@
// ----------------------------------------------------------------------------
// swmf_pkg
// Shared constants for the sliding-window sample filter.
// ----------------------------------------------------------------------------
package swmf_pkg;

    localparam int WINDOW_MAX  = 32;
    localparam int SAMPLE_BITS = 16;
    localparam int IDX_W       = $clog2(WINDOW_MAX);
    localparam int CNT_W       = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W       = SAMPLE_BITS + IDX_W;

    // filter modes
    localparam logic [1:0] MODE_PASS   = 2'd0;
    localparam logic [1:0] MODE_MEDIAN = 2'd1;
    localparam logic [1:0] MODE_MAJOR  = 2'd2;
    localparam logic [1:0] MODE_MEAN   = 2'd3;

    // register indexes
    localparam logic [0:0] REG_MODE   = 1'b0;
    localparam logic [0:0] REG_LENGTH = 1'b1;

endpackage

@@ hw/rtl/sliding_window_median_mode_mean_filter_unit.sv @@
// ----------------------------------------------------------------------------
// sliding_window_median_mode_mean_filter_unit
// Sliding-window filter: pass-through, median, majority or mean of the
// newest samples, computed by one rank/compare unit and a serial divider.
// ----------------------------------------------------------------------------
//  channel   ports                         word
//  input     s_valid s_ready s_sample      one raw sample
//  output    m_valid m_ready m_filtered    one filtered sample
//  config    psel penable pwrite paddr ... filter_mode, window_length
//
//  Per word: pass-through writes the history, then outputs; mean reads the
//  history, then runs a 21-step divider and an output state; median and
//  majority read the history, then make one rank pass per window sample
//  (n = window size), each comparing one candidate against the 32-slot window.
//  Reset (aresetn low, synchronous) restores a one-sample zero history.
//  A result waiting on m_ready holds the unit; s_ready is high only when idle.
// ----------------------------------------------------------------------------
module sliding_window_median_mode_mean_filter_unit
    import swmf_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_filtered,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_WRITE, ST_LOAD, ST_RANK, ST_DIV, ST_OUT
    } state_t;

    state_t                   state_reg;
    logic [1:0]               mode_reg;
    logic [5:0]               wlen_reg;
    logic [CNT_W-1:0]         fill_reg;
    logic [IDX_W-1:0]         wp_reg;
    logic                     zero_ok_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic [CNT_W-1:0]         n_reg;
    logic [IDX_W-1:0]         start_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     ld_v_reg;
    logic                     ld_in_reg;
    logic                     ld_zero_reg;
    logic signed [SAMPLE_BITS-1:0] win_reg [WINDOW_MAX];
    logic                     wv_reg [WINDOW_MAX];
    logic signed [SUM_W-1:0]  sum_reg;
    logic [IDX_W-1:0]         pass_reg;
    logic [IDX_W-1:0]         step_reg;
    logic signed [SAMPLE_BITS-1:0] cand_reg;
    logic [CNT_W-1:0]         lt_reg, eq_reg;
    logic signed [SAMPLE_BITS-1:0] lo_reg, hi_reg, best_reg;
    logic [CNT_W-1:0]         best_cnt_reg;
    logic [SUM_W-1:0]         quo_reg;
    logic [CNT_W-1:0]         rem_reg;
    logic [4:0]               div_cnt_reg;
    logic signed [SAMPLE_BITS-1:0] out_reg;

    // history RAM port
    logic                     ram_we;
    logic [IDX_W-1:0]         ram_addr;
    logic [SAMPLE_BITS-1:0]   ram_rdata;

    swmf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW_MAX)) u_hist (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (sample_reg),
        .rdata (ram_rdata)
    );

    assign ram_we   = (state_reg == ST_WRITE);
    assign ram_addr = ram_we ? wp_reg : (start_reg + cnt_reg[IDX_W-1:0]);

    // config port
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    always_comb begin
        case (paddr[2])
            REG_MODE:   prdata = {30'd0, mode_reg};
            REG_LENGTH: prdata = {26'd0, wlen_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // window size for this word
    logic [CNT_W-1:0] fill_next, len_c, n_next;
    logic [IDX_W-1:0] wp_next;
    assign fill_next = (fill_reg < CNT_W'(WINDOW_MAX)) ? fill_reg + 1'b1 : fill_reg;
    assign wp_next   = wp_reg + 1'b1;
    always_comb begin
        if (wlen_reg == 6'd0) len_c = CNT_W'(1);
        else if (CNT_W'(wlen_reg) > CNT_W'(WINDOW_MAX) || wlen_reg > 6'(WINDOW_MAX))
            len_c = CNT_W'(WINDOW_MAX);
        else len_c = CNT_W'(wlen_reg);
    end
    assign n_next = (len_c < fill_next) ? len_c : fill_next;

    // rank compare unit
    logic signed [SAMPLE_BITS-1:0] cand_c, rd_word;
    logic [CNT_W-1:0] lt_f, eq_f, k_lo, k_hi;
    logic             hit_lt, hit_eq;
    assign cand_c = (step_reg == '0) ? win_reg[pass_reg] : cand_reg;
    assign hit_lt = wv_reg[0] && (win_reg[0] < cand_c);
    assign hit_eq = wv_reg[0] && (win_reg[0] == cand_c);
    assign lt_f   = ((step_reg == '0) ? '0 : lt_reg) + CNT_W'(hit_lt);
    assign eq_f   = ((step_reg == '0) ? '0 : eq_reg) + CNT_W'(hit_eq);
    assign k_lo   = (n_reg - 1'b1) >> 1;
    assign k_hi   = n_reg >> 1;
    assign rd_word = ld_zero_reg ? '0 : ram_rdata;

    // divider step
    logic [SUM_W-1:0] mag_c;
    logic [CNT_W:0]   trial_c;
    logic signed [SAMPLE_BITS:0] mid_sum;
    assign mag_c   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign trial_c = {rem_reg, quo_reg[SUM_W-1]};
    assign mid_sum = {lo_reg[SAMPLE_BITS-1], lo_reg} + {hi_reg[SAMPLE_BITS-1], hi_reg};

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mode_reg    <= MODE_PASS;
            wlen_reg    <= 6'd1;
            fill_reg    <= CNT_W'(1);
            wp_reg      <= IDX_W'(1);
            zero_ok_reg <= 1'b0;
            ld_v_reg    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (paddr[2])
                    REG_MODE:   mode_reg <= pwdata[1:0];
                    REG_LENGTH: wlen_reg <= pwdata[5:0];
                    default: ;
                endcase
            end
            // read issued this cycle returns next cycle
            ld_v_reg <= (state_reg == ST_LOAD) && (cnt_reg != CNT_W'(WINDOW_MAX));
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        sample_reg <= s_sample;
                        state_reg  <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    if (wp_reg == '0) zero_ok_reg <= 1'b1;
                    wp_reg    <= wp_next;
                    fill_reg  <= fill_next;
                    n_reg     <= n_next;
                    start_reg <= wp_next - n_next[IDX_W-1:0];
                    cnt_reg   <= '0;
                    sum_reg   <= '0;
                    if (mode_reg == MODE_PASS) begin
                        out_reg   <= sample_reg;
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    if (cnt_reg != CNT_W'(WINDOW_MAX)) begin
                        ld_in_reg   <= cnt_reg < n_reg;
                        ld_zero_reg <= (ram_addr == '0) && !zero_ok_reg;
                        cnt_reg     <= cnt_reg + 1'b1;
                    end
                    if (ld_v_reg) begin
                        for (int i = 0; i < WINDOW_MAX - 1; i++) begin
                            win_reg[i] <= win_reg[i+1];
                            wv_reg[i]  <= wv_reg[i+1];
                        end
                        win_reg[WINDOW_MAX-1] <= rd_word;
                        wv_reg[WINDOW_MAX-1]  <= ld_in_reg;
                        if (ld_in_reg) sum_reg <= sum_reg + SUM_W'(rd_word);
                    end else if (cnt_reg == CNT_W'(WINDOW_MAX)) begin
                        pass_reg     <= '0;
                        step_reg     <= '0;
                        best_cnt_reg <= '0;
                        div_cnt_reg  <= '0;
                        rem_reg      <= '0;
                        quo_reg      <= mag_c;
                        state_reg    <= (mode_reg == MODE_MEAN) ? ST_DIV : ST_RANK;
                    end
                end
                ST_RANK: begin
                    for (int i = 0; i < WINDOW_MAX - 1; i++) begin
                        win_reg[i] <= win_reg[i+1];
                        wv_reg[i]  <= wv_reg[i+1];
                    end
                    win_reg[WINDOW_MAX-1] <= win_reg[0];
                    wv_reg[WINDOW_MAX-1]  <= wv_reg[0];
                    cand_reg <= cand_c;
                    lt_reg   <= lt_f;
                    eq_reg   <= eq_f;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == IDX_W'(WINDOW_MAX - 1)) begin
                        if (lt_f <= k_lo && k_lo < lt_f + eq_f) lo_reg <= cand_c;
                        if (lt_f <= k_hi && k_hi < lt_f + eq_f) hi_reg <= cand_c;
                        if (eq_f > best_cnt_reg ||
                            (eq_f == best_cnt_reg && cand_c < best_reg)) begin
                            best_cnt_reg <= eq_f;
                            best_reg     <= cand_c;
                        end
                        pass_reg <= pass_reg + 1'b1;
                        if (CNT_W'(pass_reg) == n_reg - 1'b1) state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (mode_reg == MODE_MEDIAN) begin
                        out_reg   <= mid_sum[SAMPLE_BITS:1];
                        state_reg <= ST_OUT;
                    end else if (mode_reg == MODE_MAJOR) begin
                        out_reg   <= best_reg;
                        state_reg <= ST_OUT;
                    end else if (div_cnt_reg != 5'(SUM_W)) begin
                        // restoring division of the magnitude by the count
                        if (trial_c >= {1'b0, n_reg}) begin
                            rem_reg <= CNT_W'(trial_c - {1'b0, n_reg});
                            quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
                        end else begin
                            rem_reg <= trial_c[CNT_W-1:0];
                            quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
                        end
                        div_cnt_reg <= div_cnt_reg + 1'b1;
                    end else begin
                        out_reg   <= sum_reg[SUM_W-1] ? -quo_reg[SAMPLE_BITS-1:0]
                                                      : quo_reg[SAMPLE_BITS-1:0];
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_ready) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = (state_reg == ST_OUT);
    assign m_filtered = out_reg;

endmodule

@@ hw/rtl/swmf_ram.sv @@
// ----------------------------------------------------------------------------
// swmf_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module swmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write or read one word a cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end

endmodule
